### hw/rtl/mie_pkg.sv
// Shared types and constants for the extended-Euclid modular inverse block.
package mie_pkg;

	localparam int IN_W      = 31;               // operand and remainder width
	localparam int INV_W     = 32;               // result coefficient field width
	localparam int DEF_WIDTH = 32;               // default coefficient datapath width
	localparam int DIV_STEPS = IN_W;             // one quotient bit per cycle
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [IN_W-1:0] value_a;
		logic [IN_W-1:0] value_b;
	} req_t;

	typedef struct packed {
		logic signed [INV_W-1:0] inverse;
		logic [IN_W-1:0]         gcd_value;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture operands, order them, seed coefficients
		logic div_init;  // clear partial remainder and product, load the dividend
		logic div_step;  // one restoring-division bit plus product accumulate
		logic update;    // shift the Euclid pair
		logic finish;    // fix sign, register result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic r_cur_zero;
	} sts_t;

endpackage

### hw/rtl/mie_dp.sv
// Datapath: remainder/coefficient registers, bit-serial divider and product accumulator.
module mie_dp import mie_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t request,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t result,
	output logic done
);

	logic [IN_W-1:0]  m_q, r_prev_q, r_cur_q, rem_q, dvd_q;
	logic [WIDTH-1:0] c_prev_q, c_cur_q, prod_q;
	res_t             res_q;
	logic             done_q;

	logic [IN_W:0]      trial;
	logic               qbit;
	logic [IN_W-1:0]    trial_sub;
	logic [WIDTH-1:0]   prod_next;
	logic [WIDTH-1:0]   c_fix;
	logic [WIDTH+IN_W-1:0]  m_ext;
	logic [WIDTH+INV_W-1:0] c_ext;
	logic               a_ge_b;

	assign a_ge_b = request.value_a >= request.value_b;

	// restoring division bit: shift in next dividend bit, subtract if it fits
	assign trial     = {rem_q, dvd_q[IN_W-1]};
	assign qbit      = trial >= {1'b0, r_cur_q};
	assign trial_sub = IN_W'(trial - {1'b0, r_cur_q});
	// quotient bits arrive MSB first, so product = 2*product + qbit*c_cur
	assign prod_next = {prod_q[WIDTH-2:0], 1'b0} + (qbit ? c_cur_q : '0);

	assign m_ext = {{WIDTH{1'b0}}, m_q};
	assign c_fix = c_prev_q[WIDTH-1] ? (c_prev_q + m_ext[WIDTH-1:0]) : c_prev_q;
	assign c_ext = {{INV_W{c_fix[WIDTH-1]}}, c_fix};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q      <= a_ge_b ? request.value_a : request.value_b;
			r_prev_q <= a_ge_b ? request.value_a : request.value_b;
			r_cur_q  <= a_ge_b ? request.value_b : request.value_a;
			c_prev_q <= '0;
			c_cur_q  <= WIDTH'(1);
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			dvd_q  <= r_prev_q;
			prod_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= qbit ? trial_sub : trial[IN_W-1:0];
			dvd_q  <= {dvd_q[IN_W-2:0], 1'b0};
			prod_q <= prod_next;
		end
		if (cmd.update) begin
			r_prev_q <= r_cur_q;
			r_cur_q  <= rem_q;
			c_prev_q <= c_cur_q;
			c_cur_q  <= c_prev_q - prod_q;
		end
		if (cmd.finish) begin
			res_q.inverse   <= c_ext[INV_W-1:0];
			res_q.gcd_value <= r_prev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign sts.r_cur_zero = r_cur_q == '0;
	assign result         = res_q;
	assign done           = done_q;

endmodule

### hw/rtl/mie_ctrl.sv
// Controller: sequences load, per-iteration divide and update, and finish.
module mie_ctrl import mie_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_DIV,
		ST_UPD,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHK;
						busy_q  <= 1'b1;
					end
				end
				ST_CHK: begin
					cnt_q   <= '0;
					state_q <= sts.r_cur_zero ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_CHK;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.div_init = (state_q == ST_CHK) && !sts.r_cur_zero;
		cmd.div_step = state_q == ST_DIV;
		cmd.update   = state_q == ST_UPD;
		cmd.finish   = state_q == ST_FIN;
	end

	assign busy = busy_q;

endmodule

### hw/rtl/modular_inverse_ext_euclid.sv
// Top level of the extended-Euclid modular inverse block.
//
//   channel   signals                  direction  meaning
//   item in   start, busy, request     in / out   operands value_a, value_b
//   item out  done, result             out        inverse, gcd_value
//
// An item is taken at an edge where start is high and busy is low; busy rises
// on that same edge and stays high until the result is shown.
// Each item runs n Euclid iterations (at most 44 for 31-bit operands, a
// Fibonacci pair), then a last check and the finish. Each iteration is a
// check, the bit-serial divider over all 31 quotient bits (which also
// accumulates quotient*coefficient) and an update.
// done pulses for one cycle with result valid; the receiver cannot stall.
// busy falls on the edge that raises done, so a waiting item is taken at the
// edge that ends the done cycle.
// Reset (arst_n low, asynchronous) returns the controller to idle and clears
// busy and done; datapath payload registers are not reset.
module modular_inverse_ext_euclid import mie_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH   // coefficient datapath width, 8..64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output res_t result
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: idle -> (check -> divide x31 -> update)* -> check -> finish
	mie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// remainders, coefficients, divider and result register
	mie_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result),
		.done    (done)
	);

endmodule

### hw/rtl/mie_chk.sv
// Port-level checker for the modular inverse block, with its bind.
module mie_chk import mie_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t result
);

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after item accepted");

	// a result only closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result without a preceding busy period");

	// busy ends exactly with the result strobe
	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy ended without a result");

	// the result strobe falls again after each result
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// gcd of zero only for both operands zero, where the coefficient is zero
	a_zero_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.gcd_value == '0) |-> result.inverse == '0)
		else $error("nonzero coefficient with zero gcd");

endmodule

bind modular_inverse_ext_euclid mie_chk u_mie_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

### verif/modular_inverse_ext_euclid_test.sv
// Self-checking testbench for the extended-Euclid modular inverse block.
module modular_inverse_ext_euclid_test;
	import mie_pkg::*;

	localparam int COEF_W = DEF_WIDTH;            // coefficient datapath width under test
	localparam logic [IN_W-1:0] MAX_OP = {IN_W{1'b1}};
	localparam int CYCLE_LIMIT = 4000000;         // slowest legal run taken several times
	localparam int TAIL_CYCLES = 200;             // quiet time after the last result
	localparam int REPORT_MAX = 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	res_t result;

	res_t pending_inverses[$];                    // predicted results, oldest first
	int items_sent;
	int results_checked;
	int mismatch_count;
	int stray_count;
	int coprime_items;
	int shared_factor_items;
	int cycle_count;
	int burst_left;

	modular_inverse_ext_euclid #(.WIDTH(COEF_W)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Extended Euclid on (larger, smaller), coefficient of the smaller kept
	// at COEF_W bits, two's complement, wrapping.
	function automatic res_t predict_inverse(req_t rq);
		logic [63:0] m, x, r_prev, r_cur, r_next, q;
		logic [63:0] c_prev, c_cur, c_next, mask, ext;
		res_t res;
		mask = ((64'd1 << (COEF_W - 1)) << 1) - 64'd1;
		m = (rq.value_a >= rq.value_b) ? 64'(rq.value_a) : 64'(rq.value_b);
		x = (rq.value_a >= rq.value_b) ? 64'(rq.value_b) : 64'(rq.value_a);
		r_prev = m;
		r_cur = x;
		c_prev = 64'd0;
		c_cur = 64'd1 & mask;
		while (r_cur != 64'd0) begin
			q = r_prev / r_cur;
			r_next = r_prev % r_cur;
			c_next = (c_prev - q * c_cur) & mask;
			r_prev = r_cur;
			c_prev = c_cur;
			r_cur = r_next;
			c_cur = c_next;
		end
		// negative coefficient: add the modulus once
		if (c_prev[COEF_W-1])
			c_prev = (c_prev + m) & mask;
		ext = c_prev[COEF_W-1] ? (c_prev | ~mask) : c_prev;
		res.inverse = ext[INV_W-1:0];
		res.gcd_value = r_prev[IN_W-1:0];
		return res;
	endfunction

	// Drive one item at the falling edge and hold it until taken. busy only
	// moves on the rising edge, so its value here decides the coming edge.
	task automatic send_operands(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
		req_t rq;
		res_t pred;
		bit taken;
		rq.value_a = a;
		rq.value_b = b;
		taken = 1'b0;
		@(negedge clk);
		start <= 1'b1;
		request <= rq;
		while (!taken) begin
			if (!busy)
				taken = 1'b1;
			@(posedge clk);
			if (!taken)
				@(negedge clk);
		end
		pred = predict_inverse(rq);
		pending_inverses.push_back(pred);
		items_sent++;
		if (pred.gcd_value == IN_W'(1))
			coprime_items++;
		else if (pred.gcd_value > IN_W'(1))
			shared_factor_items++;
	endtask

	// Drop start at a falling edge and keep it low while the task waits; n must be at least 1.
	task automatic hold_off(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Bursts of random length, then a gap that is mostly short, sometimes long
	// enough to land anywhere inside the divider loop or past the end of it.
	task automatic pace_sender();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 900));
			else
				hold_off($urandom_range(1, 6));
			burst_left = $urandom_range(1, 8);
		end
	endtask

	task automatic wait_drained();
		while (pending_inverses.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_operands('0, '0);                          // both zero
		send_operands('0, MAX_OP);                      // smaller is zero
		send_operands(MAX_OP, '0);
		send_operands(IN_W'(1), IN_W'(1));              // equal operands
		send_operands(MAX_OP, MAX_OP);
		send_operands(IN_W'(12345), IN_W'(12345));
		send_operands(IN_W'(1), MAX_OP);
		send_operands(MAX_OP, IN_W'(1));
		send_operands(MAX_OP, MAX_OP - IN_W'(1));       // consecutive, gcd 1
		send_operands(IN_W'(7), IN_W'(3));              // negative coefficient, m added
		send_operands(IN_W'(3), IN_W'(7));              // same pair, swapped
		send_operands(IN_W'(12), IN_W'(18));            // no inverse, gcd 6
		send_operands(IN_W'(1836311903), IN_W'(1134903170)); // Fibonacci pair, deepest loop
		send_operands(IN_W'(1134903170), IN_W'(1836311903));
		send_operands(IN_W'(1 << 30), IN_W'(3));
		send_operands(MAX_OP, IN_W'(1 << 30));
		send_operands(IN_W'(31'h5555_5555), IN_W'(31'h2AAA_AAAA)); // alternating bits
		send_operands(IN_W'(31'h2AAA_AAAA), IN_W'(31'h5555_5555));
		send_operands(IN_W'(1 << 30), IN_W'(1 << 29)); // divides evenly
		send_operands(IN_W'(2), IN_W'(1));
		send_operands(IN_W'(0), IN_W'(1));
		send_operands(IN_W'(2147483629), IN_W'(65537)); // prime modulus
		hold_off(1);
	endtask

	task automatic test_random_full(input int n);
		logic [IN_W-1:0] a, b;
		repeat (n) begin
			a = IN_W'($urandom());
			b = IN_W'($urandom());
			send_operands(a, b);
			pace_sender();
		end
	endtask

	// Mix of shapes that reach the interesting corners: shared factors,
	// equal and zero operands, small values, deep Fibonacci chains.
	task automatic test_random_shaped(input int n);
		logic [IN_W-1:0] a, b, f0, f1, ft;
		int unsigned k;
		int idx;
		repeat (n) begin
			case ($urandom_range(0, 6))
				0: begin
					a = IN_W'($urandom());
					b = IN_W'($urandom());
				end
				1: begin
					k = $urandom_range(2, 1000);
					a = IN_W'(k * $urandom_range(0, int'(MAX_OP) / k));
					b = IN_W'(k * $urandom_range(0, int'(MAX_OP) / k));
				end
				2: begin
					a = IN_W'($urandom());
					b = a;
				end
				3: begin
					a = IN_W'($urandom());
					b = '0;
					if ($urandom_range(0, 1) == 1) begin
						b = a;
						a = '0;
					end
				end
				4: begin
					a = IN_W'($urandom_range(0, 255));
					b = IN_W'($urandom_range(0, 255));
				end
				5: begin
					f0 = '0;
					f1 = IN_W'(1);
					idx = $urandom_range(1, 45);
					repeat (idx) begin
						ft = f0 + f1;
						f0 = f1;
						f1 = ft;
					end
					a = f1;
					b = f0;
				end
				default: begin
					a = IN_W'($urandom());
					b = a - IN_W'($urandom_range(0, 3));
				end
			endcase
			if ($urandom_range(0, 1) == 1)
				send_operands(b, a);
			else
				send_operands(a, b);
			pace_sender();
		end
	endtask

	task automatic test_back_to_back(input int n);
		repeat (n)
			send_operands(IN_W'($urandom()), IN_W'($urandom_range(0, 4095)));
		hold_off(1);
	endtask

	// Sender waits for the block to drain completely before going on.
	task automatic test_drain_pause(input int n);
		repeat (n) begin
			send_operands(IN_W'($urandom()), IN_W'($urandom()));
			hold_off(1);
			wait_drained();
			if ($urandom_range(0, 1) == 1)
				hold_off($urandom_range(1, 4));
		end
	endtask

	// Result checker: done marks a result for exactly one cycle.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (pending_inverses.size() == 0) begin
				stray_count++;
				if (mismatch_count + stray_count <= REPORT_MAX)
					$display("unexpected result: inverse %0d gcd %0d",
						result.inverse, result.gcd_value);
			end else begin
				want = pending_inverses.pop_front();
				results_checked++;
				if (result.inverse !== want.inverse || result.gcd_value !== want.gcd_value) begin
					mismatch_count++;
					if (mismatch_count + stray_count <= REPORT_MAX)
						$display("mismatch on result %0d: inverse %0d (want %0d), gcd %0d (want %0d)",
							results_checked, result.inverse, want.inverse,
							result.gcd_value, want.gcd_value);
				end
			end
		end
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("modular_inverse_ext_euclid_test: FAIL");
		$finish;
	end

	initial begin
		int leftover;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		items_sent = 0;
		results_checked = 0;
		mismatch_count = 0;
		stray_count = 0;
		coprime_items = 0;
		shared_factor_items = 0;
		burst_left = $urandom_range(1, 8);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_full(140);
		test_random_shaped(170);
		test_back_to_back(30);
		test_drain_pause(12);

		hold_off(1);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		leftover = pending_inverses.size();

		$display("ran %0d operand pairs in %0d cycles: %0d coprime, %0d with a shared factor",
			items_sent, cycle_count, coprime_items, shared_factor_items);
		$display("checked %0d results: %0d mismatched, %0d unexpected, %0d missing",
			results_checked, mismatch_count, stray_count, leftover);
		if (mismatch_count == 0 && stray_count == 0 && leftover == 0)
			$display("modular_inverse_ext_euclid_test: PASS");
		else
			$display("modular_inverse_ext_euclid_test: FAIL");
		$finish;
	end

endmodule
